@@ hdl/stereo_early_reflection_diffuser_macros.svh @@
// Assertion macros for the stereo early-reflection diffuser.
// Each use expects i_clk and i_rst_n in the enclosing module.
`ifndef STEREO_EARLY_REFLECTION_DIFFUSER_MACROS_SVH
`define STEREO_EARLY_REFLECTION_DIFFUSER_MACROS_SVH

// same-cycle implication
`define SERD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SERD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/serd_pkg.sv @@
// Shared types, constants and fixed-point helpers of the stereo diffuser.
// No dependencies.
`default_nettype none
package serd_pkg;
    localparam int SAMPLE_W    = 24;
    localparam int COEF_W      = 17;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int RND_W       = ACC_W - 15;
    localparam int SUM_W       = RND_W + 1;
    localparam int DELAY_DEPTH = 4096;
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
    localparam int TAP_REGS    = 6;
    localparam int TAP_COUNT   = 6;
    localparam int TAP_IW      = $clog2(TAP_REGS);
    localparam int DIFF_N      = 4;
    localparam int DIFF_POS_W  = 9;
    localparam int DIFF_LEN [DIFF_N] = '{142, 107, 379, 277};
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int DGAIN_W     = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_DGAIN_IDX = 3'd6;
    localparam logic signed [COEF_W-1:0] CROSS_GAIN = 17'sd6554;
    localparam logic signed [SUM_W-1:0] SAT_MAX = 28'sd8388607;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -28'sd8388608;

    typedef enum logic [3:0] {
        S_IDLE, S_XL, S_XR, S_XW, S_TRD, S_TML, S_TMR, S_TACC, S_SUM,
        S_AP1, S_AP2, S_AP3, S_FIN
    } t_state;

    typedef struct packed {
        logic                       mul;
        logic signed [SAMPLE_W-1:0] a;
        logic signed [COEF_W-1:0]   b;
        logic                       clr;
        logic                       acc_l;
        logic                       acc_r;
    } t_mac_cmd;

    function automatic logic signed [RND_W-1:0] round15(input logic signed [ACC_W-1:0] p);
        logic signed [ACC_W-1:0] t;
        t = p + ACC_W'(16384);
        return RND_W'(t >>> 15);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        if (v > SAT_MAX) return SAMPLE_W'(SAT_MAX);
        if (v < SAT_MIN) return SAMPLE_W'(SAT_MIN);
        return SAMPLE_W'(v);
    endfunction
endpackage
`default_nettype wire

@@ hdl/serd_ifs.sv @@
// Valid/ready stream interfaces for the diffuser input and output samples.
// Depends on serd_pkg.
`default_nettype none
interface serd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [serd_pkg::SAMPLE_W-1:0] left_in;
    logic signed [serd_pkg::SAMPLE_W-1:0] right_in;
    modport source (output valid, left_in, right_in, input ready);
    modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface serd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [serd_pkg::SAMPLE_W-1:0] left_out;
    logic signed [serd_pkg::SAMPLE_W-1:0] right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink   (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

@@ hdl/stereo_early_reflection_diffuser.sv @@
// Top level of the stereo early-reflection diffuser: sequencer, tap and
// diffuser stores, configuration registers. Depends on serd_pkg, serd_ifs,
// serd_ram, serd_mac and the macros header.
//
// One stereo sample per transfer. A single multiplier is stepped by the
// sequencer through the cross feed and store write, each tap (both channels
// share the multiplier), closing the sums, each allpass stage when the
// diffusion gain is nonzero, and loading the output register, which waits
// while the output register holds a result not yet taken. The next transfer
// is taken in the idle state. Input ready is high only while idle.
// No clearing pass: unwritten store entries read as zero via fill tracking,
// so the block is ready right after reset.
`default_nettype none
`include "stereo_early_reflection_diffuser_macros.svh"
module stereo_early_reflection_diffuser (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    serd_in_if.sink                                 s_in,
    serd_out_if.source                              m_out,
    input  wire logic                               i_cfg_we,
    input  wire logic [serd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [serd_pkg::CFG_W-1:0]         i_cfg_data
);
    localparam int SW = serd_pkg::SAMPLE_W;
    localparam int AW = serd_pkg::DELAY_AW;
    localparam logic [serd_pkg::CFG_IDX_W-1:0] CFG_IDX_TAPS =
        serd_pkg::CFG_IDX_W'(serd_pkg::TAP_REGS);

    serd_pkg::t_state r_state, n_state;

    logic [serd_pkg::CFG_W-1:0]    r_tap_cfg [serd_pkg::TAP_REGS];
    logic [serd_pkg::DGAIN_W-1:0]  r_dgain;

    logic signed [SW-1:0] r_l, r_r, r_yl, r_yr, r_ap_in, r_ap_out;
    logic [AW-1:0]        r_wp;
    logic                 r_dfill;
    logic [serd_pkg::TAP_IW-1:0] r_tap;
    logic                 r_tvalid;
    logic [1:0]           r_stg;
    logic [serd_pkg::DIFF_POS_W-1:0] r_pos [serd_pkg::DIFF_N];
    logic [serd_pkg::DIFF_N-1:0]     r_pfill;
    logic                 r_ov;
    logic signed [SW-1:0] r_ol, r_or;

    serd_pkg::t_mac_cmd            w_cmd;
    logic signed [serd_pkg::PROD_W-1:0] w_prod;
    logic signed [serd_pkg::ACC_W-1:0]  w_acc_l, w_acc_r;

    serd_mac u_mac (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .o_prod  (w_prod),
        .o_acc_l (w_acc_l),
        .o_acc_r (w_acc_r)
    );

    // fixed-point results from the product and accumulator registers
    logic signed [serd_pkg::RND_W-1:0] w_prnd;
    logic signed [SW-1:0] w_xcross, w_yl, w_yr, w_d, w_apo, w_apw;
    assign w_prnd   = serd_pkg::round15(serd_pkg::ACC_W'(w_prod));
    assign w_xcross = serd_pkg::sat24(serd_pkg::SUM_W'(r_state == serd_pkg::S_XR ? r_l : r_r)
                                      + serd_pkg::SUM_W'(w_prnd));
    assign w_yl     = serd_pkg::sat24(serd_pkg::SUM_W'(serd_pkg::round15(w_acc_l)));
    assign w_yr     = serd_pkg::sat24(serd_pkg::SUM_W'(serd_pkg::round15(w_acc_r)));
    assign w_apo    = serd_pkg::sat24(serd_pkg::SUM_W'(w_d) - serd_pkg::SUM_W'(w_prnd));
    assign w_apw    = serd_pkg::sat24(serd_pkg::SUM_W'(r_ap_in) + serd_pkg::SUM_W'(w_prnd));

    // tap address
    logic [15:0]   w_tdel;
    logic [AW-1:0] w_tdc, w_raddr;
    logic          w_rvalid;
    logic signed [15:0] w_gl, w_gr;
    assign w_tdel = r_tap_cfg[r_tap][15:0];
    assign w_gl   = $signed(r_tap_cfg[r_tap][31:16]);
    assign w_gr   = $signed(r_tap_cfg[r_tap][47:32]);
    always_comb begin
        if (w_tdel == 16'd0) begin
            w_tdc = AW'(1);
        end else if ({1'b0, w_tdel} > 17'(serd_pkg::DELAY_DEPTH - 1)) begin
            w_tdc = AW'(serd_pkg::DELAY_DEPTH - 1);
        end else begin
            w_tdc = w_tdel[AW-1:0];
        end
    end
    assign w_raddr  = r_wp - w_tdc;
    assign w_rvalid = r_dfill || (w_raddr < r_wp);

    logic [SW-1:0] w_dl_rd, w_dr_rd;
    logic          w_we_l, w_we_r;

    serd_ram #(.DEPTH(serd_pkg::DELAY_DEPTH), .WIDTH(SW)) u_dly_l (
        .i_clk (i_clk), .i_we (w_we_l), .i_waddr (r_wp), .i_wdata (w_xcross),
        .i_raddr (w_raddr), .o_rdata (w_dl_rd)
    );
    serd_ram #(.DEPTH(serd_pkg::DELAY_DEPTH), .WIDTH(SW)) u_dly_r (
        .i_clk (i_clk), .i_we (w_we_r), .i_waddr (r_wp), .i_wdata (w_xcross),
        .i_raddr (w_raddr), .o_rdata (w_dr_rd)
    );

    logic [SW-1:0] w_drd [serd_pkg::DIFF_N];
    for (genvar gi = 0; gi < serd_pkg::DIFF_N; gi++) begin : g_diff
        localparam int DAW = $clog2(serd_pkg::DIFF_LEN[gi]);
        logic w_we;
        assign w_we = (r_state == serd_pkg::S_AP3) && (r_stg == 2'(gi));
        serd_ram #(.DEPTH(serd_pkg::DIFF_LEN[gi]), .WIDTH(SW)) u_ram (
            .i_clk (i_clk), .i_we (w_we), .i_waddr (r_pos[gi][DAW-1:0]),
            .i_wdata (w_apw), .i_raddr (r_pos[gi][DAW-1:0]), .o_rdata (w_drd[gi])
        );
    end
    assign w_d = r_pfill[r_stg] ? $signed(w_drd[r_stg]) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            serd_pkg::S_IDLE: if (s_in.valid) n_state = serd_pkg::S_XL;
            serd_pkg::S_XL:   n_state = serd_pkg::S_XR;
            serd_pkg::S_XR:   n_state = serd_pkg::S_XW;
            serd_pkg::S_XW:   n_state = serd_pkg::S_TRD;
            serd_pkg::S_TRD:  n_state = serd_pkg::S_TML;
            serd_pkg::S_TML:  n_state = serd_pkg::S_TMR;
            serd_pkg::S_TMR:  n_state = (r_tap == serd_pkg::TAP_IW'(serd_pkg::TAP_COUNT - 1))
                                        ? serd_pkg::S_TACC : serd_pkg::S_TRD;
            serd_pkg::S_TACC: n_state = serd_pkg::S_SUM;
            serd_pkg::S_SUM:  n_state = (r_dgain == '0) ? serd_pkg::S_FIN : serd_pkg::S_AP1;
            serd_pkg::S_AP1:  n_state = serd_pkg::S_AP2;
            serd_pkg::S_AP2:  n_state = serd_pkg::S_AP3;
            serd_pkg::S_AP3:  n_state = (r_stg == 2'd3) ? serd_pkg::S_FIN : serd_pkg::S_AP1;
            serd_pkg::S_FIN:  if (!r_ov || m_out.ready) n_state = serd_pkg::S_IDLE;
            default:          n_state = serd_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic signed [serd_pkg::COEF_W-1:0] w_g;
    assign w_g = serd_pkg::COEF_W'($signed({2'b00, r_dgain}));
    always_comb begin
        w_cmd  = '0;
        w_we_l = 1'b0;
        w_we_r = 1'b0;
        case (r_state)
            serd_pkg::S_XL: begin
                w_cmd.mul = 1'b1; w_cmd.a = r_r; w_cmd.b = serd_pkg::CROSS_GAIN;
            end
            serd_pkg::S_XR: begin
                w_cmd.mul = 1'b1; w_cmd.a = r_l; w_cmd.b = serd_pkg::CROSS_GAIN;
                w_we_l = 1'b1;
            end
            serd_pkg::S_XW: begin
                w_we_r = 1'b1; w_cmd.clr = 1'b1;
            end
            serd_pkg::S_TRD: w_cmd.acc_r = (r_tap != '0);
            serd_pkg::S_TML: begin
                w_cmd.mul = 1'b1; w_cmd.a = r_tvalid ? $signed(w_dl_rd) : '0;
                w_cmd.b = serd_pkg::COEF_W'(w_gl);
            end
            serd_pkg::S_TMR: begin
                w_cmd.mul = 1'b1; w_cmd.a = r_tvalid ? $signed(w_dr_rd) : '0;
                w_cmd.b = serd_pkg::COEF_W'(w_gr); w_cmd.acc_l = 1'b1;
            end
            serd_pkg::S_TACC: w_cmd.acc_r = 1'b1;
            serd_pkg::S_AP1: begin
                w_cmd.mul = 1'b1; w_cmd.a = r_ap_in; w_cmd.b = w_g;
            end
            serd_pkg::S_AP2: begin
                w_cmd.mul = 1'b1; w_cmd.a = w_apo; w_cmd.b = w_g;
            end
            default: w_cmd = '0;
        endcase
    end

    assign s_in.ready      = (r_state == serd_pkg::S_IDLE);
    assign m_out.valid     = r_ov;
    assign m_out.left_out  = r_ol;
    assign m_out.right_out = r_or;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= serd_pkg::S_IDLE;
            for (int i = 0; i < serd_pkg::TAP_REGS; i++) r_tap_cfg[i] <= '0;
            r_dgain <= '0;
            r_wp    <= '0;
            r_dfill <= 1'b0;
            r_tap   <= '0;
            r_stg   <= '0;
            for (int i = 0; i < serd_pkg::DIFF_N; i++) r_pos[i] <= '0;
            r_pfill <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_IDX_TAPS) r_tap_cfg[i_cfg_idx] <= i_cfg_data;
                else if (i_cfg_idx == serd_pkg::CFG_DGAIN_IDX)
                    r_dgain <= i_cfg_data[serd_pkg::DGAIN_W-1:0];
            end
            if ((r_state == serd_pkg::S_FIN) && (!r_ov || m_out.ready)) r_ov <= 1'b1;
            else if (m_out.ready) r_ov <= 1'b0;
            case (r_state)
                serd_pkg::S_XW:  r_tap <= '0;
                serd_pkg::S_TMR: r_tap <= r_tap + 1'b1;
                serd_pkg::S_SUM: begin
                    r_wp  <= r_wp + 1'b1;
                    if (r_wp == '1) r_dfill <= 1'b1;
                    r_stg <= '0;
                end
                serd_pkg::S_AP3: begin
                    if (r_pos[r_stg] == serd_pkg::DIFF_POS_W'(serd_pkg::DIFF_LEN[r_stg] - 1)) begin
                        r_pos[r_stg]   <= '0;
                        r_pfill[r_stg] <= 1'b1;
                    end else begin
                        r_pos[r_stg] <= r_pos[r_stg] + 1'b1;
                    end
                    r_stg <= r_stg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tvalid <= w_rvalid;
        case (r_state)
            serd_pkg::S_IDLE: begin
                r_l <= s_in.left_in;
                r_r <= s_in.right_in;
            end
            serd_pkg::S_SUM: begin
                r_yl    <= w_yl;
                r_yr    <= w_yr;
                r_ap_in <= w_yl;
            end
            serd_pkg::S_AP2: r_ap_out <= w_apo;
            serd_pkg::S_AP3: begin
                case (r_stg)
                    2'd0:    r_ap_in <= r_ap_out;
                    2'd1: begin
                        r_yl    <= r_ap_out;
                        r_ap_in <= r_yr;
                    end
                    2'd2:    r_ap_in <= r_ap_out;
                    default: r_yr <= r_ap_out;
                endcase
            end
            serd_pkg::S_FIN: begin
                if (!r_ov || m_out.ready) begin
                    r_ol <= r_yl;
                    r_or <= r_yr;
                end
            end
            default: ;
        endcase
    end

    `SERD_ASSERT_NEXT(a_accept_starts, s_in.valid && s_in.ready, r_state == serd_pkg::S_XL, "transfer did not start sequencer")
    `SERD_ASSERT_NOW(a_tap_range, r_state == serd_pkg::S_TMR, r_tap < serd_pkg::TAP_IW'(serd_pkg::TAP_COUNT), "tap counter overrun")
    `SERD_ASSERT_NOW(a_ap_gain, r_state == serd_pkg::S_AP1, r_dgain != '0, "diffuser run with zero gain")
    `SERD_ASSERT_NEXT(a_wp_step, r_state == serd_pkg::S_SUM, r_wp == $past(r_wp) + 1'b1, "write position did not advance")
endmodule
`default_nettype wire

@@ hdl/serd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module serd_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/serd_mac.sv @@
// Shared multiplier with registered product and two accumulators.
// Depends on serd_pkg.
`default_nettype none
module serd_mac (
    input  wire logic                              i_clk,
    input  wire serd_pkg::t_mac_cmd                i_cmd,
    output logic signed [serd_pkg::PROD_W-1:0]     o_prod,
    output logic signed [serd_pkg::ACC_W-1:0]      o_acc_l,
    output logic signed [serd_pkg::ACC_W-1:0]      o_acc_r
);
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            o_prod <= serd_pkg::PROD_W'(i_cmd.a * i_cmd.b);
        end
        if (i_cmd.clr) begin
            o_acc_l <= '0;
            o_acc_r <= '0;
        end else begin
            if (i_cmd.acc_l) o_acc_l <= o_acc_l + serd_pkg::ACC_W'(o_prod);
            if (i_cmd.acc_r) o_acc_r <= o_acc_r + serd_pkg::ACC_W'(o_prod);
        end
    end
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the stereo early-reflection diffuser: a queue-fed
// bursty driver, a stalling sink and a transaction-level predictor of taps and allpasses.
// Depends on serd_pkg, serd_ifs and the stereo_early_reflection_diffuser RTL.
`timescale 1ns / 1ps
module testbench;
    localparam int DDEPTH   = 4096;
    localparam int WDOG_MAX = 4000;
    localparam logic [serd_pkg::CFG_IDX_W-1:0] REG_TAP_A  = 3'd0;
    localparam logic [serd_pkg::CFG_IDX_W-1:0] REG_DGAIN  = serd_pkg::CFG_DGAIN_IDX;
    localparam logic [serd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int AP_LEN [4] = '{142, 107, 379, 277};

    typedef struct packed {
        logic signed [serd_pkg::SAMPLE_W-1:0] left;
        logic signed [serd_pkg::SAMPLE_W-1:0] right;
    } t_stereo;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we;
    logic [serd_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [serd_pkg::CFG_W-1:0] i_cfg_data;

    serd_in_if  in_bus();
    serd_out_if out_bus();

    stereo_early_reflection_diffuser DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_bus), .m_out(out_bus),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    logic [47:0] tap_word [6];
    int          ap_gain;
    int          line_l [DDEPTH];
    int          line_r [DDEPTH];
    int          line_wp;
    int          ap_mem [4][512];
    int          ap_pos [4];

    t_stereo pending_samples [$];
    t_stereo expected_refl [$];
    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int n_phases = 0;

    function automatic longint rnd_q15(longint p);
        return (p + 16384) >>> 15;
    endfunction

    function automatic int clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return int'(v);
    endfunction

    function automatic int allpass_stage(int k, int x);
        int d, y;
        d = ap_mem[k][ap_pos[k]];
        y = clamp24(longint'(d) - rnd_q15(longint'(ap_gain) * x));
        ap_mem[k][ap_pos[k]] = clamp24(longint'(x) + rnd_q15(longint'(ap_gain) * y));
        ap_pos[k] = (ap_pos[k] + 1) % AP_LEN[k];
        return y;
    endfunction

    function automatic t_stereo predict_reflection(t_stereo s);
        int l, r, dly, ri, yl, yr;
        longint accl, accr;
        t_stereo res;
        l = s.left;
        r = s.right;
        line_l[line_wp] = clamp24(longint'(l) + rnd_q15(longint'(r) * 6554));
        line_r[line_wp] = clamp24(longint'(r) + rnd_q15(longint'(l) * 6554));
        accl = 0;
        accr = 0;
        for (int k = 0; k < 6; k++) begin
            dly = tap_word[k][15:0];
            if (dly < 1) dly = 1;
            if (dly > DDEPTH - 1) dly = DDEPTH - 1;
            ri = (line_wp + DDEPTH - dly) % DDEPTH;
            accl += longint'(line_l[ri]) * $signed(tap_word[k][31:16]);
            accr += longint'(line_r[ri]) * $signed(tap_word[k][47:32]);
        end
        line_wp = (line_wp + 1) % DDEPTH;
        yl = clamp24(rnd_q15(accl));
        yr = clamp24(rnd_q15(accr));
        if (ap_gain != 0) begin
            yl = allpass_stage(1, allpass_stage(0, yl));
            yr = allpass_stage(3, allpass_stage(2, yr));
        end
        res.left = yl[23:0];
        res.right = yr[23:0];
        return res;
    endfunction

    task automatic write_reg(logic [serd_pkg::CFG_IDX_W-1:0] idx,
                             logic [serd_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx < 6) tap_word[idx] = data;
        else if (idx == REG_DGAIN) ap_gain = data[14:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pending_samples.size() == 0 && !in_bus.valid && expected_refl.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_sample(int l, int r);
        t_stereo s;
        s.left = l[23:0];
        s.right = r[23:0];
        pending_samples.push_back(s);
    endtask

    function automatic logic [47:0] random_tap();
        logic [15:0] d, gl, gr;
        case ($urandom_range(0, 9))
            0: d = 16'd0;
            1: d = 16'hFFFF;
            2: d = 16'($urandom_range(4096, 65535));
            3: d = 16'($urandom_range(1, 4095));
            default: d = 16'($urandom_range(1, 300));
        endcase
        gl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
        gr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
        return {gr, gl, d};
    endfunction

    function automatic int random_sample();
        if ($urandom_range(0, 2) == 0) return $signed(24'($urandom));
        return $urandom_range(0, 2000000) - 1000000;
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    logic in_xfer = 1'b0;
    always @(posedge i_clk) in_xfer <= in_bus.valid && in_bus.ready;

    always @(negedge i_clk) begin
        logic nv;
        t_stereo s;
        nv = in_bus.valid;
        if (i_rst_n && (!in_bus.valid || in_xfer)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_samples.size() > 0) begin
                s = pending_samples.pop_front();
                in_bus.left_in <= s.left;
                in_bus.right_in <= s.right;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
        end
        in_bus.valid <= nv;
    end

    // sink stall pattern
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt = $urandom_range(50, 400);
        end
        stall_cnt--;
        case (stall_mode)
            0: out_bus.ready <= 1'b1;
            1: out_bus.ready <= ($urandom_range(0, 1) == 1);
            2: out_bus.ready <= ($urandom_range(0, 7) == 0);
            default: out_bus.ready <= (stall_cnt % 50) >= 40;
        endcase
    end

    // monitor and scoreboard
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_stereo exp_s;
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            expected_refl.push_back(predict_reflection({in_bus.left_in, in_bus.right_in}));
            n_in++;
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            n_out++;
            if (expected_refl.size() == 0) begin
                errors++;
                $display("%0t: unexpected result left=%0d right=%0d", $time,
                         out_bus.left_out, out_bus.right_out);
            end else begin
                exp_s = expected_refl.pop_front();
                if (out_bus.left_out !== exp_s.left) begin
                    errors++;
                    $display("%0t: left_out expected %0d actual %0d", $time,
                             exp_s.left, out_bus.left_out);
                end
                if (out_bus.right_out !== exp_s.right) begin
                    errors++;
                    $display("%0t: right_out expected %0d actual %0d", $time,
                             exp_s.right, out_bus.right_out);
                end
            end
        end
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_refl.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        in_bus.valid = 1'b0;
        in_bus.left_in = '0;
        in_bus.right_in = '0;
        out_bus.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        foreach (tap_word[k]) tap_word[k] = '0;
        ap_gain = 0;
        line_wp = 0;
        foreach (line_l[k]) begin
            line_l[k] = 0;
            line_r[k] = 0;
        end
        foreach (ap_mem[k, j]) ap_mem[k][j] = 0;
        foreach (ap_pos[k]) ap_pos[k] = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero taps, then delay clamps, full-scale gains, strong diffusion
        push_sample(8388607, -8388608);
        push_sample(-8388608, 8388607);
        wait_idle();
        write_reg(REG_TAP_A + 0, {16'h8000, 16'h7FFF, 16'd0});
        write_reg(REG_TAP_A + 1, {16'h7FFF, 16'h8000, 16'hFFFF});
        write_reg(REG_TAP_A + 2, {16'h4000, 16'hC000, 16'd4096});
        write_reg(REG_TAP_A + 3, {16'h8000, 16'h8000, 16'd4095});
        write_reg(REG_TAP_A + 4, {16'h7FFF, 16'h7FFF, 16'd1});
        write_reg(REG_TAP_A + 5, {16'h0100, 16'hFF00, 16'd2});
        write_reg(REG_DGAIN, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_UNUSED, 48'h1234_5678_9ABC);
        for (int i = 0; i < 10; i++) begin
            push_sample(8388607, 8388607);
            push_sample(-8388608, -8388608);
        end
        push_sample(0, 0);
        push_sample(1, -1);
        wait_idle();
        write_reg(REG_DGAIN, 48'd22938);
        push_sample(8388607, -8388608);
        push_sample(-1, 0);
        n_phases = 2;

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            for (int k = 0; k < 6; k++) write_reg(REG_TAP_A + k, random_tap());
            case (ph % 4)
                0: write_reg(REG_DGAIN, 48'd0);
                1: write_reg(REG_DGAIN, 48'd22938);
                2: write_reg(REG_DGAIN, 48'd32767);
                default: write_reg(REG_DGAIN, 48'($urandom));
            endcase
            for (int i = 0; i < 250; i++) push_sample(random_sample(), random_sample());
            n_phases++;
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        $display("Ran %0d samples over %0d register settings; %0d results checked.",
                 n_in, n_phases, n_out);
        if (errors == 0 && expected_refl.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ stereo_early_reflection_diffuser.f @@
+incdir+hdl
hdl/serd_pkg.sv
hdl/serd_ifs.sv
hdl/serd_ram.sv
hdl/serd_mac.sv
hdl/stereo_early_reflection_diffuser.sv
dv/testbench.sv
